### sv/iq_phase_atan2_unit_assert.svh
// assertion macros shared by the rtl
`ifndef IQ_PHASE_ATAN2_UNIT_ASSERT_SVH
`define IQ_PHASE_ATAN2_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IQA_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("iqa assertion failed: same-cycle implication");

`define IQA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("iqa assertion failed: next-cycle implication");

`else

`define IQA_ASSERT_IMPLY(name, clk, rstn, ante, cons)

`define IQA_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

### sv/iqa_pkg.sv
`timescale 1ns / 1ps

package iqa_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int GUARD_BITS       = 3;
    localparam int ANGLE_W          = 32;
    localparam int PHASE_W          = 16;
    localparam int STEP_IDX_W       = 5;

    localparam logic [ANGLE_W-1:0] ANGLE_POS_QUARTER = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_NEG_QUARTER = 32'hC000_0000;
    localparam logic [ANGLE_W-1:0] ROUND_HALF        = 32'h0000_8000;

    typedef struct packed {
        logic zero;
        logic last;
    } tag_t;

    // atan(2^-i) in binary angle units, full turn is 2^32
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2F9;
            5'd15:   val = 32'h0000_517C;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A2F;
            5'd19:   val = 32'h0000_0517;
            5'd20:   val = 32'h0000_028B;
            5'd21:   val = 32'h0000_0145;
            5'd22:   val = 32'h0000_00A2;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0028;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0002;
            5'd29:   val = 32'h0000_0001;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### sv/iqa_stage.sv
`timescale 1ns / 1ps

module iqa_stage #(
    parameter int DATA_W = iqa_pkg::SAMPLE_BITS_DEF + iqa_pkg::GUARD_BITS,
    parameter int STEP   = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DATA_W-1:0]          in_x,
    input  logic signed [DATA_W-1:0]          in_y,
    input  logic [iqa_pkg::ANGLE_W-1:0]       in_z,
    input  iqa_pkg::tag_t                     in_tag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_W-1:0]          out_x,
    output logic signed [DATA_W-1:0]          out_y,
    output logic [iqa_pkg::ANGLE_W-1:0]       out_z,
    output iqa_pkg::tag_t                     out_tag
);

    localparam logic [iqa_pkg::ANGLE_W-1:0] ATAN_STEP =
        iqa_pkg::atan_entry(iqa_pkg::STEP_IDX_W'(STEP));

    logic signed [DATA_W-1:0]        dx;
    logic signed [DATA_W-1:0]        dy;
    logic                            rot_cw;
    logic                            valid_reg;
    logic                            valid_next;
    logic signed [DATA_W-1:0]        x_reg;
    logic signed [DATA_W-1:0]        x_next;
    logic signed [DATA_W-1:0]        y_reg;
    logic signed [DATA_W-1:0]        y_next;
    logic [iqa_pkg::ANGLE_W-1:0]     z_reg;
    logic [iqa_pkg::ANGLE_W-1:0]     z_next;
    iqa_pkg::tag_t                   tag_reg;

    assign dx     = in_y >>> STEP;
    assign dy     = in_x >>> STEP;
    assign rot_cw = !in_y[DATA_W-1];

    always_comb begin
        if (rot_cw) begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_STEP;
        end else begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_STEP;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

### sv/iq_phase_atan2_unit.sv
// channel  | ports                                          | handshake
// request  | s_in_phase, s_quadrature, s_last_sample        | s_valid / s_ready
// result   | m_phase_angle, m_last_out                      | m_valid / m_ready
//
// one request per cycle sustained while m_ready stays high
// stages: quadrant pre-rotation register, one register per cordic iteration,
// rounding output register
// reset clears the valid bit of every stage, payload registers are not reset
// a stage loads when it is empty or its successor loads, so bubbles close up
// and a stall on m_ready backs up stage by stage
`timescale 1ns / 1ps
`include "iq_phase_atan2_unit_assert.svh"

module iq_phase_atan2_unit #(
    parameter int SAMPLE_BITS  = iqa_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = iqa_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_in_phase,
    input  logic signed [SAMPLE_BITS-1:0]      s_quadrature,
    input  logic                               s_last_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [iqa_pkg::PHASE_W-1:0] m_phase_angle,
    output logic                               m_last_out
);

    localparam int DATA_W = SAMPLE_BITS + iqa_pkg::GUARD_BITS;

    logic signed [DATA_W-1:0]        x_arr   [0:CORDIC_STEPS];
    logic signed [DATA_W-1:0]        y_arr   [0:CORDIC_STEPS];
    logic [iqa_pkg::ANGLE_W-1:0]     z_arr   [0:CORDIC_STEPS];
    iqa_pkg::tag_t                   tag_arr [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]           valid_arr;
    logic [CORDIC_STEPS+1:0]         rdy_arr;
    logic [CORDIC_STEPS+1:0]         occ;

    // pre-rotation into the right half plane
    logic signed [DATA_W-1:0]        xi;
    logic signed [DATA_W-1:0]        yi;
    logic signed [DATA_W-1:0]        x0_next;
    logic signed [DATA_W-1:0]        y0_next;
    logic [iqa_pkg::ANGLE_W-1:0]     z0_next;
    iqa_pkg::tag_t                   tag0_next;
    logic signed [DATA_W-1:0]        x0_reg;
    logic signed [DATA_W-1:0]        y0_reg;
    logic [iqa_pkg::ANGLE_W-1:0]     z0_reg;
    iqa_pkg::tag_t                   tag0_reg;
    logic                            valid0_reg;
    logic                            valid0_next;

    assign xi = {{iqa_pkg::GUARD_BITS{s_in_phase[SAMPLE_BITS-1]}}, s_in_phase};
    assign yi = {{iqa_pkg::GUARD_BITS{s_quadrature[SAMPLE_BITS-1]}}, s_quadrature};

    always_comb begin
        tag0_next.zero = (s_in_phase == '0) && (s_quadrature == '0);
        tag0_next.last = s_last_sample;
        if (!xi[DATA_W-1]) begin
            x0_next = xi;
            y0_next = yi;
            z0_next = '0;
        end else if (!yi[DATA_W-1]) begin
            x0_next = yi;
            y0_next = -xi;
            z0_next = iqa_pkg::ANGLE_POS_QUARTER;
        end else begin
            x0_next = -yi;
            y0_next = xi;
            z0_next = iqa_pkg::ANGLE_NEG_QUARTER;
        end
    end

    assign rdy_arr[0]  = !valid0_reg || rdy_arr[1];
    assign s_ready     = rdy_arr[0];
    assign valid0_next = rdy_arr[0] ? s_valid : valid0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else begin
            valid0_reg <= valid0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_arr[0] && s_valid) begin
            x0_reg   <= x0_next;
            y0_reg   <= y0_next;
            z0_reg   <= z0_next;
            tag0_reg <= tag0_next;
        end
    end

    assign valid_arr[0] = valid0_reg;
    assign x_arr[0]     = x0_reg;
    assign y_arr[0]     = y0_reg;
    assign z_arr[0]     = z0_reg;
    assign tag_arr[0]   = tag0_reg;

    // cordic iterations, one per stage
    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_iter
        iqa_stage #(
            .DATA_W (DATA_W),
            .STEP   (k - 1)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_arr[k-1]),
            .in_ready  (rdy_arr[k]),
            .in_x      (x_arr[k-1]),
            .in_y      (y_arr[k-1]),
            .in_z      (z_arr[k-1]),
            .in_tag    (tag_arr[k-1]),
            .out_valid (valid_arr[k]),
            .out_ready (rdy_arr[k+1]),
            .out_x     (x_arr[k]),
            .out_y     (y_arr[k]),
            .out_z     (z_arr[k]),
            .out_tag   (tag_arr[k])
        );
    end

    // rounding and output register
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [iqa_pkg::ANGLE_W-1:0]     z_round;
    logic [iqa_pkg::PHASE_W-1:0]     phase_next;
    logic [iqa_pkg::PHASE_W-1:0]     phase_reg;
    logic                            last_reg;

    assign z_round    = z_arr[CORDIC_STEPS] + iqa_pkg::ROUND_HALF;
    assign phase_next = tag_arr[CORDIC_STEPS].zero ? '0 :
                        z_round[iqa_pkg::ANGLE_W-1 -: iqa_pkg::PHASE_W];

    assign rdy_arr[CORDIC_STEPS+1] = !m_valid_reg || m_ready;
    assign m_valid_next = rdy_arr[CORDIC_STEPS+1] ? valid_arr[CORDIC_STEPS] : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_arr[CORDIC_STEPS+1] && valid_arr[CORDIC_STEPS]) begin
            phase_reg <= phase_next;
            last_reg  <= tag_arr[CORDIC_STEPS].last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_phase_angle = phase_reg;
    assign m_last_out    = last_reg;

    assign occ = {m_valid_reg, valid_arr};

    `IQA_ASSERT_IMPLY(a_full_blocks_input, aclk, aresetn, ((&occ) && !m_ready), (!s_ready))
    `IQA_ASSERT_IMPLY(a_bubble_frees_input, aclk, aresetn, (!(&occ)), (s_ready))
    `IQA_ASSERT_NEXT(a_prerot_right_half, aclk, aresetn, (s_valid && s_ready), (!x0_reg[DATA_W-1]))

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import iqa_pkg::*;

    localparam int SW     = SAMPLE_BITS_DEF;
    localparam int NSTEPS = CORDIC_STEPS_DEF;

    localparam logic [ANGLE_W-1:0] ATAN_LUT [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
        32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
    };

    localparam logic signed [SW-1:0] EDGE_VALUES [6] = '{
        -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
    };

    typedef struct {
        logic signed [PHASE_W-1:0] angle;
        logic                      last;
    } phase_result_t;

    class phase_scoreboard;
        phase_result_t expected_phases[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic signed [PHASE_W-1:0] cordic_phase(logic signed [SW-1:0] i_val,
                                                         logic signed [SW-1:0] q_val);
            longint             x;
            longint             y;
            longint             t;
            longint             dx;
            longint             dy;
            logic [ANGLE_W-1:0] z;
            int                 steps;
            x = i_val;
            y = q_val;
            z = '0;
            if (x == 0 && y == 0) begin
                return '0;
            end
            // left half plane: turn by a quarter first
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = ANGLE_POS_QUARTER;
                end else begin
                    x = -y;
                    y = t;
                    z = ANGLE_NEG_QUARTER;
                end
            end
            steps = (NSTEPS > 32) ? 32 : NSTEPS;
            for (int k = 0; k < steps; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_LUT[k];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_LUT[k];
                end
            end
            z = z + ROUND_HALF;
            return z[ANGLE_W-1:ANGLE_W-PHASE_W];
        endfunction

        function void note_request(logic signed [SW-1:0] i_val, logic signed [SW-1:0] q_val,
                                   logic last);
            phase_result_t r;
            r.angle = cordic_phase(i_val, q_val);
            r.last  = last;
            expected_phases.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic signed [PHASE_W-1:0] angle, logic last);
            phase_result_t r;
            if (expected_phases.size() == 0) begin
                report_mismatch($sformatf("unexpected result angle %0d last %0b", angle, last));
                return;
            end
            r = expected_phases.pop_front();
            if (angle !== r.angle) begin
                report_mismatch($sformatf("angle %0d, expected %0d", angle, r.angle));
            end
            if (last !== r.last) begin
                report_mismatch($sformatf("last %0b, expected %0b", last, r.last));
            end
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [SW-1:0]      s_in_phase;
    logic signed [SW-1:0]      s_quadrature;
    logic                      s_last_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [PHASE_W-1:0] m_phase_angle;
    logic                      m_last_out;

    int              send_idle_pct;
    int              recv_idle_pct;
    phase_scoreboard sb;

    iq_phase_atan2_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_phase    (s_in_phase),
        .s_quadrature  (s_quadrature),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_phase_angle (m_phase_angle),
        .m_last_out    (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_in_phase, s_quadrature, s_last_sample);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_phase_angle, m_last_out);
            end
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] i_val,
                               input logic signed [SW-1:0] q_val, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_phase    <= i_val;
        s_quadrature  <= q_val;
        s_last_sample <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random_samples(input int count);
        logic signed [SW-1:0] i_val;
        logic signed [SW-1:0] q_val;
        logic signed [SW-1:0] mag;
        int                   pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            mag  = SW'($urandom);
            if (pick < 40) begin
                i_val = SW'($urandom);
                q_val = SW'($urandom);
            end else if (pick < 55) begin
                i_val = SW'(int'($urandom_range(16)) - 8);
                q_val = SW'(int'($urandom_range(16)) - 8);
            end else if (pick < 70) begin
                // axes and diagonals
                case ($urandom_range(3))
                    0: begin i_val = mag; q_val = '0; end
                    1: begin i_val = '0; q_val = mag; end
                    2: begin i_val = mag; q_val = mag; end
                    default: begin i_val = mag; q_val = -mag; end
                endcase
            end else if (pick < 80) begin
                i_val = EDGE_VALUES[$urandom_range(5)];
                q_val = EDGE_VALUES[$urandom_range(5)];
            end else begin
                i_val = mag >>> $urandom_range(SW - 1);
                q_val = $signed(16'($urandom)) >>> $urandom_range(SW - 1);
            end
            send_sample(i_val, q_val, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_in_phase    = '0;
        s_quadrature  = '0;
        s_last_sample = 1'b0;
        m_ready       = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 75;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero sample, axes, corners, left half plane and the pi wrap
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd32767, 16'sd0, 1'b1);
        send_sample(-16'sd32768, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd32767, 1'b0);
        send_sample(16'sd0, -16'sd32768, 1'b1);
        send_sample(16'sd32767, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(-16'sd1, 16'sd0, 1'b0);
        send_sample(-16'sd1, -16'sd1, 1'b1);
        send_sample(-16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd0, -16'sd1, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd1, -16'sd1, 1'b1);
        send_sample(-16'sd32768, -16'sd1, 1'b0);
        send_sample(-16'sd32768, 16'sd1, 1'b1);
        send_sample(16'sd100, -16'sd100, 1'b0);
        send_sample(-16'sd100, 16'sd100, 1'b1);

        run_random_samples(600);
        send_idle_pct = 75;
        recv_idle_pct = 17;
        run_random_samples(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_samples(550);
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.expected_phases.size() != 0) @(posedge aclk);
        repeat (NSTEPS + 20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_phases.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
